>>> rtl/core/dqr_pkg.sv
// Shared types and constants for the double-ended queue with reverse.
// Used by dqr_cell, deque_with_reverse, dqr_checker and the bench; depends on nothing.
`timescale 1ns / 1ps

package dqr_pkg;

	localparam int DEPTH = 64;
	localparam int DATA_W = 64;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int FUNC_W = 3;
	localparam int S_TDATA_W = ((DATA_W + 7) / 8) * 8;
	localparam int S_TUSER_W = ((FUNC_W + 7) / 8) * 8;
	localparam int M_FIELDS_W = 2 * DATA_W + CNT_W + 2;
	localparam int M_TDATA_W = ((M_FIELDS_W + 7) / 8) * 8;

	typedef enum logic [FUNC_W-1:0] {
		FN_PUSH_FRONT = 3'd0,
		FN_PUSH_BACK  = 3'd1,
		FN_POP_FRONT  = 3'd2,
		FN_POP_BACK   = 3'd3,
		FN_REVERSE    = 3'd4,
		FN_NONE       = 3'd5
	} func_t;

	typedef enum logic [2:0] {
		OP_HOLD,
		OP_SHIFT_R,
		OP_PUSH_R,
		OP_SHIFT_L,
		OP_POP_R
	} cell_op_t;

	typedef struct packed {
		cell_op_t            op;
		logic [DATA_W-1:0]   value;
	} cell_ctrl_t;

endpackage

>>> rtl/core/dqr_cell.sv
// One storage cell of the deque chain: a value and a tail marker, both
// moved between neighbors as the operation demands. Depends on dqr_pkg.
`timescale 1ns / 1ps

module dqr_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  dqr_pkg::cell_ctrl_t         ctrl,
	input  logic [dqr_pkg::DATA_W-1:0]  left_data,
	input  logic                        left_last,
	input  logic [dqr_pkg::DATA_W-1:0]  right_data,
	input  logic                        right_last,
	output logic [dqr_pkg::DATA_W-1:0]  data,
	output logic                        last,
	output logic [dqr_pkg::DATA_W-1:0]  tail_out
);

	logic [dqr_pkg::DATA_W-1:0] data_q;
	logic                       last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= 1'b0;
		end else begin
			case (ctrl.op) inside
				dqr_pkg::OP_SHIFT_R, dqr_pkg::OP_PUSH_R: last_q <= left_last;
				dqr_pkg::OP_SHIFT_L, dqr_pkg::OP_POP_R:  last_q <= right_last;
				default:                                 last_q <= last_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ctrl.op)
			dqr_pkg::OP_SHIFT_R: data_q <= left_data;
			dqr_pkg::OP_PUSH_R: begin
				if (left_last) begin
					data_q <= ctrl.value;
				end
			end
			dqr_pkg::OP_SHIFT_L: data_q <= right_data;
			default:             data_q <= data_q;
		endcase
	end

	// present the value only while this cell holds the tail
	assign tail_out = last_q ? data_q : '0;
	assign data     = data_q;
	assign last     = last_q;

endmodule

>>> rtl/core/deque_with_reverse.sv
// Double-ended queue of 64-bit values with constant-time reverse.
// The state updates at the input transfer, and the result register loads
// from the updated state once the output register is free.
// Throughput: one operation per cycle while results are taken every cycle.
// Reset: count, orientation, tail markers and valid flags clear at once;
// stored values are not cleared and no clearing pass runs.
`timescale 1ns / 1ps

module deque_with_reverse (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [dqr_pkg::S_TDATA_W-1:0]   s_tdata,  // value
	input  logic [dqr_pkg::S_TUSER_W-1:0]   s_tuser,  // func, zero fill
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [dqr_pkg::M_TDATA_W-1:0]   m_tdata   // front_value, back_value,
	                                                  // count, is_empty, error, zero fill
);

	localparam logic [dqr_pkg::CNT_W-1:0] FULL_CNT = dqr_pkg::CNT_W'(dqr_pkg::DEPTH);

	logic [dqr_pkg::CNT_W-1:0]  count_q;
	logic                       flip_q;
	logic                       valid_s1;
	logic                       err_s1;
	logic                       out_valid_q;
	logic [dqr_pkg::DATA_W-1:0] front_q;
	logic [dqr_pkg::DATA_W-1:0] back_q;
	logic [dqr_pkg::CNT_W-1:0]  cnt_out_q;
	logic                       empty_out_q;
	logic                       err_out_q;

	logic                       accept;
	logic                       out_free;
	logic                       advance;
	logic                       empty;
	logic                       full;
	logic                       err;
	logic                       to_left;
	logic [dqr_pkg::CNT_W-1:0]  count_d;
	logic                       flip_d;
	dqr_pkg::cell_ctrl_t        ctrl;
	dqr_pkg::func_t             func;

	logic [dqr_pkg::DATA_W-1:0] cell_data [dqr_pkg::DEPTH];
	logic                       cell_last [dqr_pkg::DEPTH];
	logic [dqr_pkg::DATA_W-1:0] tail_tree [2*dqr_pkg::DEPTH-1];
	logic [dqr_pkg::DATA_W-1:0] left_val;
	logic [dqr_pkg::DATA_W-1:0] right_val;

	assign out_free = !out_valid_q || m_tready;
	assign advance  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;
	assign accept   = s_tvalid && s_tready;
	assign empty    = (count_q == '0);
	assign full     = (count_q == FULL_CNT);
	assign func     = dqr_pkg::func_t'(s_tuser[dqr_pkg::FUNC_W-1:0]);

	always_comb begin
		err        = 1'b0;
		to_left    = 1'b0;
		count_d    = count_q;
		flip_d     = flip_q;
		ctrl.op    = dqr_pkg::OP_HOLD;
		ctrl.value = s_tdata[dqr_pkg::DATA_W-1:0];
		if (accept) begin
			unique case (func) inside
				dqr_pkg::FN_PUSH_FRONT, dqr_pkg::FN_PUSH_BACK: begin
					if (full) begin
						err = 1'b1;
					end else begin
						to_left = (func == dqr_pkg::FN_PUSH_FRONT) != flip_q;
						ctrl.op = to_left ? dqr_pkg::OP_SHIFT_R : dqr_pkg::OP_PUSH_R;
						count_d = count_q + 1'b1;
					end
				end
				dqr_pkg::FN_POP_FRONT, dqr_pkg::FN_POP_BACK: begin
					if (empty) begin
						err = 1'b1;
					end else begin
						to_left = (func == dqr_pkg::FN_POP_FRONT) != flip_q;
						ctrl.op = to_left ? dqr_pkg::OP_SHIFT_L : dqr_pkg::OP_POP_R;
						count_d = count_q - 1'b1;
					end
				end
				dqr_pkg::FN_REVERSE: begin
					if (empty) begin
						err = 1'b1;
					end else begin
						flip_d = !flip_q;
					end
				end
				default: begin
					err = 1'b0;
				end
			endcase
		end
	end

	for (genvar i = 0; i < dqr_pkg::DEPTH; i++) begin : g_cell
		logic [dqr_pkg::DATA_W-1:0] l_data;
		logic                       l_last;
		logic [dqr_pkg::DATA_W-1:0] r_data;
		logic                       r_last;
		if (i == 0) begin : g_first
			assign l_data = s_tdata[dqr_pkg::DATA_W-1:0];
			assign l_last = empty;
		end else begin : g_inner
			assign l_data = cell_data[i-1];
			assign l_last = cell_last[i-1];
		end
		if (i == dqr_pkg::DEPTH - 1) begin : g_end
			assign r_data = '0;
			assign r_last = 1'b0;
		end else begin : g_mid
			assign r_data = cell_data[i+1];
			assign r_last = cell_last[i+1];
		end
		dqr_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.left_data  (l_data),
			.left_last  (l_last),
			.right_data (r_data),
			.right_last (r_last),
			.data       (cell_data[i]),
			.last       (cell_last[i]),
			.tail_out   (tail_tree[dqr_pkg::DEPTH-1+i])
		);
	end

	// merge the one-hot tail values pairwise down to the root
	for (genvar k = 0; k < dqr_pkg::DEPTH - 1; k++) begin : g_tail_or
		assign tail_tree[k] = tail_tree[2*k+1] | tail_tree[2*k+2];
	end

	assign left_val  = empty ? '0 : cell_data[0];
	assign right_val = tail_tree[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			flip_q      <= 1'b0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			flip_q  <= flip_d;
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			err_s1 <= err;
		end
		if (advance) begin
			front_q     <= flip_q ? right_val : left_val;
			back_q      <= flip_q ? left_val : right_val;
			cnt_out_q   <= count_q;
			empty_out_q <= empty;
			err_out_q   <= err_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(dqr_pkg::M_TDATA_W - dqr_pkg::M_FIELDS_W){1'b0}},
		err_out_q, empty_out_q, cnt_out_q, back_q, front_q};

endmodule

>>> rtl/core/dqr_checker.sv
// Port-level checks for deque_with_reverse, attached by bind.
// Depends on dqr_pkg.
`timescale 1ns / 1ps

module dqr_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [dqr_pkg::M_TDATA_W-1:0]   m_tdata
);

	localparam int CNT_LO = 2 * dqr_pkg::DATA_W;

	logic [dqr_pkg::DATA_W-1:0] front;
	logic [dqr_pkg::DATA_W-1:0] back;
	logic [dqr_pkg::CNT_W-1:0]  cnt;
	logic                       is_empty;
	logic                       error;

	assign front    = m_tdata[dqr_pkg::DATA_W-1:0];
	assign back     = m_tdata[CNT_LO-1:dqr_pkg::DATA_W];
	assign cnt      = m_tdata[CNT_LO+dqr_pkg::CNT_W-1:CNT_LO];
	assign is_empty = m_tdata[CNT_LO+dqr_pkg::CNT_W];
	assign error    = m_tdata[CNT_LO+dqr_pkg::CNT_W+1];

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (is_empty == (cnt == '0)) &&
			(!is_empty || (front == '0 && back == '0)))
		else $error("empty result carries data or wrong count");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (cnt <= dqr_pkg::CNT_W'(dqr_pkg::DEPTH)))
		else $error("count beyond depth");

	a_err_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && error) |-> (cnt == '0 || cnt == dqr_pkg::CNT_W'(dqr_pkg::DEPTH)))
		else $error("error flagged while neither empty nor full");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("stalled result changed");

endmodule

bind deque_with_reverse dqr_checker u_dqr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

>>> tb/deque_with_reverse_test.sv
// Self-checking bench for deque_with_reverse: mirrors the ring store, head, count and
// orientation, and compares every result transfer field by field under varied idling.
// Depends on dqr_pkg and deque_with_reverse.
`timescale 1ns / 1ps

module deque_with_reverse_test;
	import dqr_pkg::*;

	localparam logic [FUNC_W-1:0] FN_SPARE_6 = 3'd6;
	localparam logic [FUNC_W-1:0] FN_SPARE_7 = 3'd7;
	localparam logic [DATA_W-1:0] ALL_ONES = '1;

	typedef struct {
		logic [FUNC_W-1:0] func;
		logic [DATA_W-1:0] value;
	} deque_op_t;

	typedef struct packed {
		logic [M_TDATA_W-M_FIELDS_W-1:0] pad;
		logic                            error;
		logic                            is_empty;
		logic [CNT_W-1:0]                count;
		logic [DATA_W-1:0]               back_value;
		logic [DATA_W-1:0]               front_value;
	} deque_view_t;

	typedef enum int {BURST_FILL, BURST_MIXED, BURST_DRAIN} burst_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic [S_TUSER_W-1:0] s_tuser = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;

	deque_op_t   op_backlog[$];
	deque_view_t view_pending[$];
	int          ops_queued = 0;
	int          ops_taken = 0;
	int          mismatches = 0;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;

	logic [DATA_W-1:0] ring_mem[DEPTH];
	int                ring_head = 0;
	int                ring_fill = 0;
	logic              ring_flipped = 1'b0;

	burst_t burst_mode = BURST_FILL;
	int     burst_left = 0;
	int     burst_index = 0;

	deque_with_reverse dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic deque_view_t apply_deque_op(logic [FUNC_W-1:0] func,
			logic [DATA_W-1:0] value);
		deque_view_t r;
		logic        at_left;
		logic [DATA_W-1:0] left_v;
		logic [DATA_W-1:0] right_v;
		r = '0;
		case (func)
			FN_PUSH_FRONT, FN_PUSH_BACK: begin
				if (ring_fill >= DEPTH) begin
					r.error = 1'b1;
				end else begin
					at_left = (func == FN_PUSH_FRONT) ^ ring_flipped;
					if (at_left) begin
						ring_head = (ring_head + DEPTH - 1) % DEPTH;
						ring_mem[ring_head] = value;
					end else begin
						ring_mem[(ring_head + ring_fill) % DEPTH] = value;
					end
					ring_fill++;
				end
			end
			FN_POP_FRONT, FN_POP_BACK: begin
				if (ring_fill == 0) begin
					r.error = 1'b1;
				end else begin
					at_left = (func == FN_POP_FRONT) ^ ring_flipped;
					if (at_left) ring_head = (ring_head + 1) % DEPTH;
					ring_fill--;
				end
			end
			FN_REVERSE: begin
				if (ring_fill == 0) r.error = 1'b1;
				else ring_flipped = ~ring_flipped;
			end
			default: ;
		endcase
		if (ring_fill != 0) begin
			left_v = ring_mem[ring_head];
			right_v = ring_mem[(ring_head + ring_fill - 1) % DEPTH];
			r.front_value = ring_flipped ? right_v : left_v;
			r.back_value = ring_flipped ? left_v : right_v;
		end
		r.count = CNT_W'(ring_fill);
		r.is_empty = (ring_fill == 0);
		return r;
	endfunction

	function automatic logic [DATA_W-1:0] random_word();
		return {$urandom(), $urandom()};
	endfunction

	function automatic logic [FUNC_W-1:0] random_func();
		int roll;
		roll = $urandom_range(99);
		case (burst_mode)
			BURST_FILL: begin
				if (roll < 90) return $urandom_range(1) ? FN_PUSH_BACK : FN_PUSH_FRONT;
				if (roll < 95) return $urandom_range(1) ? FN_POP_BACK : FN_POP_FRONT;
				if (roll < 98) return FN_REVERSE;
				return $urandom_range(1) ? FN_NONE : FN_SPARE_6;
			end
			BURST_DRAIN: begin
				if (roll < 85) return $urandom_range(1) ? FN_POP_BACK : FN_POP_FRONT;
				if (roll < 92) return $urandom_range(1) ? FN_PUSH_BACK : FN_PUSH_FRONT;
				if (roll < 97) return FN_REVERSE;
				return $urandom_range(1) ? FN_NONE : FN_SPARE_7;
			end
			default: begin
				if (roll < 35) return $urandom_range(1) ? FN_PUSH_BACK : FN_PUSH_FRONT;
				if (roll < 70) return $urandom_range(1) ? FN_POP_BACK : FN_POP_FRONT;
				if (roll < 85) return FN_REVERSE;
				if (roll < 92) return FN_NONE;
				return $urandom_range(1) ? FN_SPARE_7 : FN_SPARE_6;
			end
		endcase
	endfunction

	task automatic queue_op(logic [FUNC_W-1:0] func, logic [DATA_W-1:0] value);
		deque_op_t it;
		it.func = func;
		it.value = value;
		op_backlog.push_back(it);
		ops_queued++;
	endtask

	task automatic run_phase(int send_pct, int recv_pct, int n_ops);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		repeat (n_ops) begin
			if (burst_left == 0) begin
				case (burst_index % 4)
					0: burst_mode = BURST_FILL;
					2: burst_mode = BURST_DRAIN;
					default: burst_mode = BURST_MIXED;
				endcase
				burst_left = (burst_mode == BURST_MIXED) ? $urandom_range(40, 20)
				                                          : $urandom_range(90, 70);
				burst_index++;
			end
			queue_op(random_func(), random_word());
			burst_left--;
		end
		while (ops_taken != ops_queued) @(posedge clk);
	endtask

	// driver: advance to the next operation once the current transfer completes
	always @(posedge clk or negedge arst_n) begin
		deque_op_t it;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
		end else if (!s_tvalid || s_tready) begin
			if (op_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				it = op_backlog.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= S_TDATA_W'(it.value);
				s_tuser <= S_TUSER_W'(it.func);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_tready <= 1'b0;
		else m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// monitor: predict on each operation transfer, check on each result transfer
	always @(posedge clk) begin
		deque_view_t want;
		deque_view_t got;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				view_pending.push_back(apply_deque_op(s_tuser[FUNC_W-1:0],
					s_tdata[DATA_W-1:0]));
				ops_taken++;
			end
			if (m_tvalid && m_tready) begin
				got = deque_view_t'(m_tdata);
				if (view_pending.size() == 0) begin
					$display("%0t: result with none pending: %h", $time, m_tdata);
					mismatches++;
				end else begin
					want = view_pending.pop_front();
					if (got.front_value !== want.front_value) begin
						$display("%0t: front_value expected %h got %h", $time,
							want.front_value, got.front_value);
						mismatches++;
					end
					if (got.back_value !== want.back_value) begin
						$display("%0t: back_value expected %h got %h", $time,
							want.back_value, got.back_value);
						mismatches++;
					end
					if (got.count !== want.count) begin
						$display("%0t: count expected %0d got %0d", $time,
							want.count, got.count);
						mismatches++;
					end
					if (got.is_empty !== want.is_empty) begin
						$display("%0t: is_empty expected %b got %b", $time,
							want.is_empty, got.is_empty);
						mismatches++;
					end
					if (got.error !== want.error) begin
						$display("%0t: error expected %b got %b", $time,
							want.error, got.error);
						mismatches++;
					end
				end
			end
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		queue_op(FN_POP_FRONT, random_word());
		queue_op(FN_POP_BACK, random_word());
		queue_op(FN_REVERSE, random_word());
		queue_op(FN_NONE, random_word());
		queue_op(FN_SPARE_6, random_word());
		queue_op(FN_SPARE_7, random_word());
		queue_op(FN_PUSH_FRONT, ALL_ONES);
		queue_op(FN_REVERSE, '0);
		queue_op(FN_POP_BACK, '0);
		queue_op(FN_PUSH_BACK, '0);
		queue_op(FN_PUSH_FRONT, 64'h8000_0000_0000_0000);
		queue_op(FN_PUSH_BACK, 64'h5555_5555_5555_5555);
		queue_op(FN_PUSH_FRONT, 64'hAAAA_AAAA_AAAA_AAAA);
		queue_op(FN_REVERSE, '0);
		queue_op(FN_POP_FRONT, '0);
		queue_op(FN_PUSH_FRONT, 64'h1);
		queue_op(FN_PUSH_BACK, 64'hFFFF_FFFF_FFFF_FFFE);
		queue_op(FN_SPARE_7, ALL_ONES);
		queue_op(FN_POP_BACK, '0);
		queue_op(FN_REVERSE, '0);
		queue_op(FN_POP_FRONT, '0);
		queue_op(FN_POP_FRONT, '0);
		queue_op(FN_POP_BACK, '0);
		queue_op(FN_POP_BACK, '0);
		queue_op(FN_POP_FRONT, '0);

		run_phase(0, 0, 100);
		run_phase(84, 0, 100);
		run_phase(0, 84, 100);
		run_phase(17, 17, 100);

		while (view_pending.size() > 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0) begin
			$display("deque_with_reverse_test OK");
		end else begin
			$display("deque_with_reverse_test NOT OK");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("deque_with_reverse_test NOT OK");
		$finish;
	end

endmodule
